[rtl/cpd_pkg.sv]
// Shared types and constants for the COBS packet deframer.
// Used by cpd_front, cpd_queue, cpd_back and cobs_packet_deframer; no dependencies.
`default_nettype none

package cpd_pkg;

  // Encoded frame position width (bytes accepted within a frame)
  localparam int unsigned PosWidth    = 9;
  // Decoded header bytes ahead of the payload
  localparam int unsigned HeaderBytes = 4;
  // Entries in the front-to-back queue
  localparam int unsigned QueueDepth  = 2;

  // Label of a decoded byte
  typedef enum logic [2:0] {
    KindSeq      = 3'd0,
    KindIdA      = 3'd1,
    KindIdB      = 3'd2,
    KindLen      = 3'd3,
    KindPayload  = 3'd4,
    KindChecksum = 3'd5,
    KindEnd      = 3'd6
  } kind_e;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic [7:0] index;
  } cpd_item_t;

endpackage

`default_nettype wire

[rtl/cpd_front.sv]
// Front end: COBS decode and field labelling of received bytes.
// Depends on cpd_pkg; pushes labelled bytes toward cpd_queue.
`default_nettype none

module cpd_front #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     push_valid_o,
  input  wire logic                push_ready_i,
  output cpd_pkg::cpd_item_t       push_item_o
);

  localparam int unsigned PW = cpd_pkg::PosWidth;
  localparam logic [PW-1:0] LastPos = PW'(MAX_FRAME_BYTES - 1);

  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] code_pos_q, code_pos_d;
  logic [7:0]    len_q, len_d;

  logic          accept;
  logic [PW-1:0] dec_idx;
  logic [PW:0]   dec_idx_w;
  logic [PW:0]   pay_end;
  logic [7:0]    val;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // decoded byte number and the checksum slot
  assign dec_idx   = pos_q - PW'(1);
  assign dec_idx_w = {1'b0, dec_idx};
  assign pay_end   = (PW+1)'(cpd_pkg::HeaderBytes) + {{(PW-7){1'b0}}, len_q};
  assign val       = (pos_q == code_pos_q) ? 8'd0 : rx_byte_i;

  // classify one byte and advance frame state
  always_comb begin
    pos_d        = pos_q;
    code_pos_d   = code_pos_q;
    len_d        = len_q;
    push_valid_o = 1'b0;
    push_item_o  = '{data: 8'd0, kind: cpd_pkg::KindEnd, index: 8'd0};
    if (accept) begin
      if (rx_byte_i == 8'd0) begin
        // delimiter: status transaction and frame clear
        push_valid_o = 1'b1;
        pos_d        = '0;
        code_pos_d   = '0;
        len_d        = '0;
      end else if (pos_q < LastPos) begin
        pos_d = pos_q + PW'(1);
        if (pos_q == '0) begin
          code_pos_d = {{(PW-8){1'b0}}, rx_byte_i};
        end else begin
          if (pos_q == code_pos_q) begin
            code_pos_d = pos_q + {{(PW-8){1'b0}}, rx_byte_i};
          end
          push_item_o.data = val;
          if (dec_idx_w < (PW+1)'(cpd_pkg::HeaderBytes)) begin
            push_valid_o     = 1'b1;
            push_item_o.kind = cpd_pkg::kind_e'(dec_idx[2:0]);
            if (push_item_o.kind == cpd_pkg::KindLen) begin
              len_d = val;
            end
          end else if (dec_idx_w < pay_end) begin
            push_valid_o      = 1'b1;
            push_item_o.kind  = cpd_pkg::KindPayload;
            push_item_o.index = 8'(dec_idx - PW'(cpd_pkg::HeaderBytes));
          end else if (dec_idx_w == pay_end) begin
            push_valid_o     = 1'b1;
            push_item_o.kind = cpd_pkg::KindChecksum;
          end
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      code_pos_q <= '0;
      len_q      <= '0;
    end else begin
      pos_q      <= pos_d;
      code_pos_q <= code_pos_d;
      len_q      <= len_d;
    end
  end

endmodule

`default_nettype wire

[rtl/cpd_queue.sv]
// Short FIFO between front and back of the deframer.
// Depends on cpd_pkg for the item type and depth.
`default_nettype none

module cpd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  input  wire cpd_pkg::cpd_item_t push_item_i,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i,
  output cpd_pkg::cpd_item_t      pop_item_o
);

  localparam int unsigned Depth = cpd_pkg::QueueDepth;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);

  cpd_pkg::cpd_item_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == $past(count_q) - CW'(1))
    else $error("queue count did not drop on pop");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("queue count past depth");
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_ready_o && !pop_ready_i |=> !push_ready_o)
    else $error("full queue freed without a pop");
`endif

endmodule

`default_nettype wire

[rtl/cpd_back.sv]
// Back end: checksum tracking and registered result output.
// Depends on cpd_pkg; pops labelled bytes from cpd_queue.
`default_nettype none

module cpd_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               pop_valid_i,
  output logic                    pop_ready_o,
  input  wire cpd_pkg::cpd_item_t pop_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              data_byte_o,
  output logic [2:0]              field_kind_o,
  output logic [7:0]              payload_index_o,
  output logic                    frame_end_o,
  output logic                    checksum_ok_o
);

  logic       valid_q;
  logic [7:0] data_q, index_q;
  logic [2:0] kind_q;
  logic       end_q, ok_q;
  logic [7:0] xor_q;
  logic       match_q;
  logic       pop;

  assign pop         = pop_valid_i && pop_ready_o;
  assign pop_ready_o = !valid_q || out_ready_i;

  // output valid and checksum state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      xor_q   <= '0;
      match_q <= 1'b0;
    end else begin
      if (pop_ready_o) begin
        valid_q <= pop_valid_i;
      end
      if (pop) begin
        unique case (pop_item_i.kind)
          cpd_pkg::KindPayload:  xor_q <= xor_q ^ pop_item_i.data;
          cpd_pkg::KindChecksum: match_q <= (pop_item_i.data == xor_q);
          cpd_pkg::KindEnd: begin
            xor_q   <= '0;
            match_q <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      data_q  <= pop_item_i.data;
      kind_q  <= pop_item_i.kind;
      index_q <= pop_item_i.index;
      end_q   <= (pop_item_i.kind == cpd_pkg::KindEnd);
      ok_q    <= (pop_item_i.kind == cpd_pkg::KindEnd) && match_q;
    end
  end

  assign out_valid_o     = valid_q;
  assign data_byte_o     = data_q;
  assign field_kind_o    = kind_q;
  assign payload_index_o = index_q;
  assign frame_end_o     = end_q;
  assign checksum_ok_o   = ok_q;

endmodule

`default_nettype wire

[rtl/cobs_packet_deframer.sv]
// A classified byte is written to the queue, then popped into the output register.
// Throughput: one byte per cycle while out_ready_i is high; the front decode
// and the back checksum stage each take one byte a cycle, a two-entry queue parts
// them. Bytes that yield no result (first code, trailing, overlong) push nothing.
// Reset (rst_ni low, asynchronous) clears frame state, queue and output.
// Depends on cpd_pkg, cpd_front, cpd_queue and cpd_back.
`default_nettype none

module cobs_packet_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      data_byte_o,
  output logic [2:0]      field_kind_o,
  output logic [7:0]      payload_index_o,
  output logic            frame_end_o,
  output logic            checksum_ok_o
);

  logic               push_valid, push_ready;
  cpd_pkg::cpd_item_t push_item;
  logic               pop_valid, pop_ready;
  cpd_pkg::cpd_item_t pop_item;

  // decode and label
  cpd_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_byte_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  // decoupling queue
  cpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  // checksum and output register
  cpd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .field_kind_o   (field_kind_o),
    .payload_index_o(payload_index_o),
    .frame_end_o    (frame_end_o),
    .checksum_ok_o  (checksum_ok_o)
  );

`ifndef SYNTHESIS
  a_ok_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && checksum_ok_o |-> frame_end_o)
    else $error("checksum_ok outside frame end");
  a_index_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_index_o != 8'd0 |->
      field_kind_o == cpd_pkg::KindPayload)
    else $error("payload index on non-payload transaction");
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire
